// ===== src/mst_pkg.sv =====
// ----------------------------------------------------------------------------
// Multitouch slot tracker package
// Shared types and constants for the contact slot chain.
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int unsigned IdW    = 64;
  localparam int unsigned NormW  = 16;
  localparam int unsigned PixW   = 12;
  localparam int unsigned EdgeW  = 14;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [PixW-1:0] ScreenWidthRst  = 12'd800;
  localparam logic [PixW-1:0] ScreenHeightRst = 12'd600;

  typedef enum logic [1:0] {
    ACT_DOWN   = 2'd0,
    ACT_UP     = 2'd1,
    ACT_MOTION = 2'd2,
    ACT_QUERY  = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    action_e                  action;
    logic [IdW-1:0]           id;
    logic [PixW-1:0]          px;
    logic [PixW-1:0]          py;
    logic signed [EdgeW-1:0]  left;
    logic signed [EdgeW-1:0]  top;
    logic signed [EdgeW-1:0]  right;
    logic signed [EdgeW-1:0]  bottom;
    logic                     done;
    logic                     hit;
  } token_t;

endpackage

// ===== src/mst_cell.sv =====
// ----------------------------------------------------------------------------
// Multitouch slot tracker cell
// Holds one contact slot and applies the passing command token to it.
// ----------------------------------------------------------------------------
module mst_cell
  import mst_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_vld_i,
  input  token_t in_tok_i,
  output logic   out_vld_o,
  output token_t out_tok_o
);

  logic            slot_vld_q, slot_vld_d;
  logic [IdW-1:0]  slot_id_q, slot_id_d;
  logic [PixW-1:0] slot_px_q, slot_px_d;
  logic [PixW-1:0] slot_py_q, slot_py_d;
  logic            tok_vld_q;
  token_t          tok_q, tok_d;
  logic            act;
  logic            match;
  logic            in_rect;
  logic signed [EdgeW-1:0] sx;
  logic signed [EdgeW-1:0] sy;

  assign sx      = $signed({{(EdgeW-PixW){1'b0}}, slot_px_q});
  assign sy      = $signed({{(EdgeW-PixW){1'b0}}, slot_py_q});
  assign act     = in_vld_i && !in_tok_i.done;
  assign match   = slot_vld_q && (slot_id_q == in_tok_i.id);
  assign in_rect = slot_vld_q && (sx >= in_tok_i.left) && (sx <= in_tok_i.right) &&
                   (sy >= in_tok_i.top) && (sy <= in_tok_i.bottom);

  always_comb begin
    slot_vld_d = slot_vld_q;
    slot_id_d  = slot_id_q;
    slot_px_d  = slot_px_q;
    slot_py_d  = slot_py_q;
    tok_d      = in_tok_i;
    if (act) begin
      case (in_tok_i.action)
        ACT_DOWN: begin
          if (!slot_vld_q) begin
            slot_vld_d = 1'b1;
            slot_id_d  = in_tok_i.id;
            slot_px_d  = in_tok_i.px;
            slot_py_d  = in_tok_i.py;
            tok_d.done = 1'b1;
          end
        end
        ACT_UP: begin
          if (match) begin
            slot_vld_d = 1'b0;
            tok_d.done = 1'b1;
          end
        end
        ACT_MOTION: begin
          if (match) begin
            slot_px_d  = in_tok_i.px;
            slot_py_d  = in_tok_i.py;
            tok_d.done = 1'b1;
          end
        end
        ACT_QUERY: begin
          if (in_rect) begin
            tok_d.hit  = 1'b1;
            tok_d.done = 1'b1;
          end
        end
        default: begin
          tok_d = in_tok_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= 1'b0;
      tok_vld_q  <= 1'b0;
    end else begin
      slot_vld_q <= slot_vld_d;
      tok_vld_q  <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_id_q <= slot_id_d;
    slot_px_q <= slot_px_d;
    slot_py_q <= slot_py_d;
    tok_q     <= tok_d;
  end

  assign out_vld_o = tok_vld_q;
  assign out_tok_o = tok_q;

endmodule

// ===== src/multitouch_slot_tracker_top.sv =====
// ----------------------------------------------------------------------------
// Multitouch slot tracker
// Table of touch contact slots handling finger down, up, motion and area query.
// ----------------------------------------------------------------------------
// Each accepted command produces exactly one touching_o result, shown for one
// cycle with strobe_o once the command has passed the launch register and every
// slot cell; the receiver cannot hold a result off and must take it in that
// cycle. busy stays high until the strobe cycle ends, so no new command is
// taken while one is in the chain. The command is scaled to pixels as it is
// accepted and then walks the chain of slot cells, one cell per cycle.
// touching_o is 1 only for a query that finds a contact in the rectangle.
// ----------------------------------------------------------------------------
module multitouch_slot_tracker_top
  import mst_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               action_i,
  input  logic [IdW-1:0]           contact_id_i,
  input  logic [NormW-1:0]         norm_x_i,
  input  logic [NormW-1:0]         norm_y_i,
  input  logic signed [12:0]       rect_left_i,
  input  logic signed [12:0]       rect_top_i,
  input  logic [PixW-1:0]          rect_width_i,
  input  logic [PixW-1:0]          rect_height_i,
  output logic                     strobe_o,
  output logic                     touching_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [PixW-1:0]          cfg_data_i
);

  logic [PixW-1:0]       width_q, width_d;
  logic [PixW-1:0]       height_q, height_d;
  logic                  busy_q, busy_d;
  logic                  accept;
  logic [NormW+PixW-1:0] prod_x;
  logic [NormW+PixW-1:0] prod_y;
  logic signed [EdgeW-1:0] left;
  logic signed [EdgeW-1:0] top;
  token_t                launch_d;
  logic                  chain_vld [NUM_SLOTS+1];
  token_t                chain_tok [NUM_SLOTS+1];

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SCREEN_WIDTH:  width_d  = cfg_data_i;
        CFG_SCREEN_HEIGHT: height_d = cfg_data_i;
        default: begin
          width_d  = width_q;
          height_d = height_q;
        end
      endcase
    end
  end

  assign accept = start && !busy_q;
  assign busy_d = busy_q ? !chain_vld[NUM_SLOTS] : accept;

  assign prod_x = norm_x_i * width_q;
  assign prod_y = norm_y_i * height_q;
  assign left   = {rect_left_i[12], rect_left_i};
  assign top    = {rect_top_i[12], rect_top_i};

  always_comb begin
    launch_d.action = action_e'(action_i);
    launch_d.id     = contact_id_i;
    launch_d.px     = prod_x[NormW+PixW-1:NormW];
    launch_d.py     = prod_y[NormW+PixW-1:NormW];
    launch_d.left   = left;
    launch_d.top    = top;
    launch_d.right  = left + $signed({{(EdgeW-PixW){1'b0}}, rect_width_i});
    launch_d.bottom = top + $signed({{(EdgeW-PixW){1'b0}}, rect_height_i});
    launch_d.done   = 1'b0;
    launch_d.hit    = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= ScreenWidthRst;
      height_q     <= ScreenHeightRst;
      busy_q       <= 1'b0;
      chain_vld[0] <= 1'b0;
    end else begin
      width_q      <= width_d;
      height_q     <= height_d;
      busy_q       <= busy_d;
      chain_vld[0] <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      chain_tok[0] <= launch_d;
    end
  end

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    mst_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .in_vld_i  (chain_vld[g]),
      .in_tok_i  (chain_tok[g]),
      .out_vld_o (chain_vld[g+1]),
      .out_tok_o (chain_tok[g+1])
    );
  end

  assign busy       = busy_q;
  assign strobe_o   = chain_vld[NUM_SLOTS];
  assign touching_o = chain_vld[NUM_SLOTS] && chain_tok[NUM_SLOTS].hit;

endmodule
